// ===== sv/tccp_pkg.sv =====
`default_nettype none
package tccp_pkg;

	localparam int MAX_COLS    = 128;
	localparam int MAX_ROWS    = 64;
	localparam int COL_W       = $clog2(MAX_COLS);
	localparam int ROW_W       = $clog2(MAX_ROWS);
	localparam int ADDR_W      = COL_W + ROW_W;
	localparam int STORE_DEPTH = MAX_COLS * MAX_ROWS;

	localparam logic [7:0] CH_BS       = 8'h08;
	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_LF       = 8'h0a;
	localparam logic [7:0] CH_CR       = 8'h0d;
	localparam logic [7:0] CH_ESC      = 8'h1b;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_0        = 8'h30;
	localparam logic [7:0] CH_9        = 8'h39;
	localparam logic [7:0] CH_SEMI     = 8'h3b;
	localparam logic [7:0] CH_K        = 8'h6b;
	localparam logic [7:0] CH_X        = 8'h78;
	localparam logic [7:0] CURSOR_MARK = 8'h80;
	localparam logic [2:0] TAB_LAST    = 3'd7;

	localparam logic [0:0] REG_WIDTH  = 1'b0;
	localparam logic [0:0] REG_HEIGHT = 1'b1;

	typedef enum logic [1:0] {
		KIND_CELL   = 2'd0,
		KIND_CLEAR  = 2'd1,
		KIND_SCROLL = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic [COL_W-1:0]   col;
		logic [ROW_W-1:0]   row;
		logic [7:0]         code;
		logic               last;
	} result_t;

	typedef struct packed {
		logic    push;
		logic    end_item;
		result_t res;
	} res_push_t;

	typedef struct packed {
		logic              we;
		logic [ADDR_W-1:0] waddr;
		logic [7:0]        wdata;
		logic              re;
		logic [ADDR_W-1:0] raddr;
	} store_req_t;

	typedef enum logic [2:0] {
		ST_CLR,
		ST_IDLE,
		ST_TOG1,
		ST_BODY,
		ST_TAB,
		ST_LAST,
		ST_TOG2
	} state_t;

endpackage
`default_nettype wire

// ===== sv/tccp_char_if.sv =====
`default_nettype none
interface tccp_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       first_of_string;
	logic       last_of_string;

	modport source(output valid, char_code, first_of_string, last_of_string, input ready);
	modport sink(input valid, char_code, first_of_string, last_of_string, output ready);
endinterface
`default_nettype wire

// ===== sv/tccp_res_if.sv =====
`default_nettype none
interface tccp_res_if;
	logic       valid;
	logic       ready;
	logic [1:0] kind;
	logic [6:0] col;
	logic [5:0] row;
	logic [7:0] code;
	logic       last;

	modport source(output valid, kind, col, row, code, last, input ready);
	modport sink(input valid, kind, col, row, code, last, output ready);
endinterface
`default_nettype wire

// ===== sv/tccp_cfg_if.sv =====
`default_nettype none
interface tccp_cfg_if;
	logic       valid;
	logic       ready;
	logic [0:0] index;
	logic [7:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== sv/tccp_store.sv =====
`default_nettype none
module tccp_store (
	input  logic                clk,
	input  tccp_pkg::store_req_t req,
	output logic [7:0]          rd_data_q
);
	import tccp_pkg::*;

	logic [7:0] mem [STORE_DEPTH];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_data_q <= mem[req.raddr];
		end
	end

endmodule
`default_nettype wire

// ===== sv/tccp_result_stage.sv =====
`default_nettype none
module tccp_result_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  tccp_pkg::res_push_t rq,
	output logic                emit_ok,
	tccp_res_if.source          results
);
	import tccp_pkg::*;

	logic    pend_valid_q;
	logic    pend_done_q;
	result_t pend_q;
	logic    out_valid_q;
	result_t out_q;
	logic    out_free;
	logic    mv;

	// pending result is held back until we know whether it closes its request
	assign out_free = !out_valid_q || results.ready;
	assign emit_ok  = !pend_valid_q || out_free;
	assign mv       = pend_valid_q && out_free && (pend_done_q || rq.push);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			pend_done_q  <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (rq.push) begin
				pend_valid_q <= 1'b1;
				pend_done_q  <= rq.end_item;
			end else if (mv) begin
				pend_valid_q <= 1'b0;
			end else if (rq.end_item && pend_valid_q) begin
				pend_done_q <= 1'b1;
			end
			if (mv) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rq.push) begin
			pend_q <= rq.res;
		end
		if (mv) begin
			out_q <= '{kind: pend_q.kind, col: pend_q.col, row: pend_q.row,
				code: pend_q.code, last: pend_done_q};
		end
	end

	assign results.valid = out_valid_q;
	assign results.kind  = out_q.kind;
	assign results.col   = out_q.col;
	assign results.row   = out_q.row;
	assign results.code  = out_q.code;
	assign results.last  = out_q.last;

endmodule
`default_nettype wire

// ===== sv/text_console_char_processor.sv =====
// Path: a request is taken into the input buffer, the item sequencer handles it, and its
// result passes the pending and output registers of the result stage to the output.
// One character is processed at a time (single store port, item sequencer), the next waiting in
// the input buffer; cursor toggles, last of string, tab cells and the clear sweep of a scroll or
// erase to end of line add steps, and stalls add on top. Reset: asynchronous, active low; the store
// is then swept to spaces, during which no request is taken (configuration writes still are).
`default_nettype none
module text_console_char_processor (
	input  logic       clk,
	input  logic       arst_n,
	tccp_char_if.sink  chars,
	tccp_res_if.source results,
	tccp_cfg_if.sink   cfg
);
	import tccp_pkg::*;

	state_t            state_q, state_d;
	logic [7:0]        col_q, col_d;
	logic [ROW_W-1:0]  row_q, row_d;
	logic [ROW_W-1:0]  top_q, top_d;
	logic              esc_act_q, esc_act_d;
	logic              past_q, past_d;
	logic [15:0]       param_q, param_d;
	logic [7:0]        tab_q, tab_d;
	logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
	logic [ADDR_W-1:0] clr_end_q, clr_end_d;
	logic              init_q, init_d;
	logic [7:0]        width_q;
	logic [6:0]        height_q;

	logic              buf_valid_q;
	logic [7:0]        buf_ch_q;
	logic              buf_first_q;
	logic              buf_last_q;
	logic [7:0]        cur_ch_q, cur_ch_d;
	logic              cur_last_q, cur_last_d;
	logic              load;

	logic [7:0]        eff_w;
	logic [6:0]        eff_h;
	logic              row_on;
	logic              cur_on;
	logic [ROW_W-1:0]  phys;
	logic [ADDR_W-1:0] cur_addr;
	logic [7:0]        bs_col;
	logic              bs_on;
	logic              tab_on;
	logic              lf_down;
	logic              is_digit;
	logic [19:0]       param_x10;
	logic [15:0]       param_sat;
	logic [7:0]        x_col;
	logic [7:0]        col_inc;
	logic [7:0]        tab_next;
	logic [COL_W-1:0]  w_last;
	logic [7:0]        rd_data_q;
	logic              emit_ok;
	logic              body_emit;
	result_t           body_res;
	logic              body_we;
	logic [ADDR_W-1:0] body_waddr;

	res_push_t         rq;
	store_req_t        sreq;

	assign eff_w    = (width_q > 8'(MAX_COLS)) ? 8'(MAX_COLS) : width_q;
	assign eff_h    = (height_q > 7'(MAX_ROWS)) ? 7'(MAX_ROWS) : height_q;
	assign row_on   = {1'b0, row_q} < eff_h;
	assign cur_on   = (col_q < eff_w) && row_on;
	assign phys     = top_q + row_q;
	assign cur_addr = {phys, col_q[COL_W-1:0]};
	assign bs_col   = col_q - 8'd1;
	assign bs_on    = (bs_col < eff_w) && row_on;
	assign tab_on   = (tab_q < eff_w) && row_on;
	assign lf_down  = ({1'b0, row_q} + 7'd1) < eff_h;
	assign is_digit = (cur_ch_q >= CH_0) && (cur_ch_q <= CH_9);
	assign param_x10 = 20'({param_q, 3'b000}) + 20'({param_q, 1'b0}) + 20'(cur_ch_q[3:0]);
	assign param_sat = (param_x10 > 20'hffff) ? 16'hffff : param_x10[15:0];
	assign x_col    = (param_q >= {8'b0, eff_w}) ? ((eff_w != 8'd0) ? eff_w - 8'd1 : 8'd0)
	                                            : param_q[7:0];
	assign col_inc  = (col_q == 8'hff) ? col_q : col_q + 8'd1;
	assign tab_next = (tab_q == 8'hff) ? tab_q : tab_q + 8'd1;
	assign w_last   = COL_W'(eff_w - 8'd1);

	assign chars.ready = !init_q && (!buf_valid_q || load);
	assign cfg.ready   = 1'b1;

	// what the body step emits, if anything
	always_comb begin
		body_emit  = 1'b0;
		body_res   = '0;
		body_we    = 1'b0;
		body_waddr = cur_addr;
		if (esc_act_q) begin
			if (cur_ch_q == CH_K && cur_on) begin
				body_emit     = 1'b1;
				body_res.kind = KIND_CLEAR;
				body_res.col  = col_q[COL_W-1:0];
				body_res.row  = row_q;
				body_res.code = CH_SPACE;
			end
		end else begin
			unique case (cur_ch_q)
				CH_LF: begin
					if (!lf_down) begin
						body_emit     = 1'b1;
						body_res.kind = KIND_SCROLL;
					end
				end
				CH_BS: begin
					if (col_q != 8'd0 && bs_on) begin
						body_emit     = 1'b1;
						body_we       = 1'b1;
						body_waddr    = {phys, bs_col[COL_W-1:0]};
						body_res.kind = KIND_CELL;
						body_res.col  = bs_col[COL_W-1:0];
						body_res.row  = row_q;
						body_res.code = CH_SPACE;
					end
				end
				CH_CR, CH_TAB, CH_ESC: begin
				end
				default: begin
					if (cur_on) begin
						body_emit     = 1'b1;
						body_we       = 1'b1;
						body_res.kind = KIND_CELL;
						body_res.col  = col_q[COL_W-1:0];
						body_res.row  = row_q;
						body_res.code = cur_ch_q;
					end
				end
			endcase
		end
	end

	always_comb begin
		state_d    = state_q;
		col_d      = col_q;
		row_d      = row_q;
		top_d      = top_q;
		esc_act_d  = esc_act_q;
		past_d     = past_q;
		param_d    = param_q;
		tab_d      = tab_q;
		clr_addr_d = clr_addr_q;
		clr_end_d  = clr_end_q;
		init_d     = init_q;
		cur_ch_d   = cur_ch_q;
		cur_last_d = cur_last_q;
		load       = 1'b0;
		rq         = '0;
		sreq       = '0;
		sreq.raddr = cur_addr;
		sreq.waddr = cur_addr;

		unique case (state_q)
			ST_CLR: begin
				sreq.we    = 1'b1;
				sreq.waddr = clr_addr_q;
				sreq.wdata = CH_SPACE;
				clr_addr_d = clr_addr_q + 1'b1;
				if (clr_addr_q == clr_end_q) begin
					init_d  = 1'b0;
					state_d = init_q ? ST_IDLE : ST_LAST;
				end
			end
			ST_IDLE: begin
				if (buf_valid_q) begin
					load       = 1'b1;
					cur_ch_d   = buf_ch_q;
					cur_last_d = buf_last_q;
					state_d    = ST_BODY;
					if (buf_first_q) begin
						esc_act_d = 1'b0;
						past_d    = 1'b0;
						param_d   = '0;
						if (cur_on) begin
							sreq.re = 1'b1;
							state_d = ST_TOG1;
						end
					end
				end
			end
			ST_TOG1, ST_TOG2: begin
				rq.res.kind = KIND_CELL;
				rq.res.col  = col_q[COL_W-1:0];
				rq.res.row  = row_q;
				rq.res.code = rd_data_q ^ CURSOR_MARK;
				if (emit_ok) begin
					rq.push    = 1'b1;
					sreq.we    = 1'b1;
					sreq.wdata = rd_data_q ^ CURSOR_MARK;
					if (state_q == ST_TOG2) begin
						rq.end_item = 1'b1;
						state_d     = ST_IDLE;
					end else begin
						state_d = ST_BODY;
					end
				end
			end
			ST_BODY: begin
				rq.res = body_res;
				if (!body_emit || emit_ok) begin
					rq.push     = body_emit;
					sreq.we     = body_we;
					sreq.waddr  = body_waddr;
					sreq.wdata  = body_res.code;
					state_d     = cur_last_q ? ST_LAST : ST_IDLE;
					rq.end_item = !cur_last_q;
					if (esc_act_q) begin
						if (is_digit) begin
							if (!past_q) begin
								param_d = param_sat;
							end
						end else if (cur_ch_q == CH_SEMI) begin
							past_d = 1'b1;
						end else begin
							esc_act_d = 1'b0;
							if (cur_ch_q == CH_K && cur_on) begin
								clr_addr_d  = cur_addr;
								clr_end_d   = {phys, w_last};
								state_d     = ST_CLR;
								rq.end_item = 1'b0;
							end else if (cur_ch_q == CH_X) begin
								col_d = x_col;
							end
						end
					end else begin
						unique case (cur_ch_q)
							CH_CR: col_d = '0;
							CH_LF: begin
								col_d = '0;
								if (lf_down) begin
									row_d = row_q + 1'b1;
								end else begin
									top_d       = top_q + 1'b1;
									clr_addr_d  = {top_q, {COL_W{1'b0}}};
									clr_end_d   = {top_q, {COL_W{1'b1}}};
									state_d     = ST_CLR;
									rq.end_item = 1'b0;
								end
							end
							CH_TAB: begin
								if (col_q[2:0] != 3'd0) begin
									tab_d       = col_q;
									state_d     = ST_TAB;
									rq.end_item = 1'b0;
								end
							end
							CH_BS: begin
								if (col_q != 8'd0) begin
									col_d = bs_col;
								end
							end
							CH_ESC: begin
								esc_act_d = 1'b1;
								past_d    = 1'b0;
								param_d   = '0;
							end
							default: col_d = col_inc;
						endcase
					end
				end
			end
			ST_TAB: begin
				rq.res.kind = KIND_CELL;
				rq.res.col  = tab_q[COL_W-1:0];
				rq.res.row  = row_q;
				rq.res.code = CH_SPACE;
				if (!tab_on || emit_ok) begin
					rq.push    = tab_on;
					sreq.we    = tab_on;
					sreq.waddr = {phys, tab_q[COL_W-1:0]};
					sreq.wdata = CH_SPACE;
					tab_d      = tab_next;
					if (tab_q[2:0] == TAB_LAST) begin
						col_d   = tab_next;
						state_d = ST_LAST;
					end
				end
			end
			ST_LAST: begin
				if (cur_last_q && cur_on) begin
					sreq.re = 1'b1;
					state_d = ST_TOG2;
				end else begin
					rq.end_item = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q       <= '0;
			row_q       <= '0;
			top_q       <= '0;
			esc_act_q   <= 1'b0;
			past_q      <= 1'b0;
			param_q     <= '0;
			tab_q       <= '0;
			clr_addr_q  <= '0;
			clr_end_q   <= '1;
			init_q      <= 1'b1;
			width_q     <= 8'd80;
			height_q    <= 7'd25;
			buf_valid_q <= 1'b0;
		end else begin
			col_q      <= col_d;
			row_q      <= row_d;
			top_q      <= top_d;
			esc_act_q  <= esc_act_d;
			past_q     <= past_d;
			param_q    <= param_d;
			tab_q      <= tab_d;
			clr_addr_q <= clr_addr_d;
			clr_end_q  <= clr_end_d;
			init_q     <= init_d;
			if (cfg.valid) begin
				unique case (cfg.index)
					REG_WIDTH:  width_q  <= cfg.data;
					REG_HEIGHT: height_q <= cfg.data[6:0];
				endcase
			end
			if (chars.valid && chars.ready) begin
				buf_valid_q <= 1'b1;
			end else if (load) begin
				buf_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		cur_ch_q   <= cur_ch_d;
		cur_last_q <= cur_last_d;
		if (chars.valid && chars.ready) begin
			buf_ch_q    <= chars.char_code;
			buf_first_q <= chars.first_of_string;
			buf_last_q  <= chars.last_of_string;
		end
	end

	tccp_store u_store (
		.clk       (clk),
		.req       (sreq),
		.rd_data_q (rd_data_q)
	);

	tccp_result_stage u_res (
		.clk     (clk),
		.arst_n  (arst_n),
		.rq      (rq),
		.emit_ok (emit_ok),
		.results (results)
	);

endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
	import tccp_pkg::*;

	typedef struct {
		bit         is_cfg;
		logic [0:0] reg_idx;
		logic [7:0] byte_val;
		bit         first;
		bit         last;
		bit         typed;
		result_t    exp;
	} dir_row_t;

	logic clk;
	logic arst_n;

	tccp_char_if chars_ch ();
	tccp_res_if  res_ch ();
	tccp_cfg_if  cfg_ch ();

	text_console_char_processor dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.chars   (chars_ch),
		.results (res_ch),
		.cfg     (cfg_ch)
	);

	// screen model
	logic [7:0] screen_mem [0:STORE_DEPTH-1];
	logic [7:0] width_reg;
	logic [6:0] height_reg;
	int         cur_col;
	int         cur_row;
	int         top;
	bit         esc_on;
	bit         esc_semi;
	int         esc_num;

	result_t    step_ops[$];
	result_t    screen_ops_due[$];
	dir_row_t   dir_tab[$];

	int         bad_count = 0;
	int         sent = 0;
	int         burst_left = 0;
	logic [15:0] rx_cyc = '0;

	always #5 clk = ~clk;

	function automatic int vis_w();
		return (width_reg < MAX_COLS) ? int'(width_reg) : MAX_COLS;
	endfunction

	function automatic int vis_h();
		return (height_reg < MAX_ROWS) ? int'(height_reg) : MAX_ROWS;
	endfunction

	function automatic int cell_addr(int c, int r);
		return ((top + r) % MAX_ROWS) * MAX_COLS + (c % MAX_COLS);
	endfunction

	function automatic void put_cell(int c, int r, logic [7:0] v);
		if (c >= vis_w() || r >= vis_h())
			return;
		screen_mem[cell_addr(c, r)] = v;
		step_ops.push_back('{kind: KIND_CELL, col: COL_W'(c), row: ROW_W'(r), code: v,
			last: 1'b0});
	endfunction

	function automatic void flip_cursor();
		if (cur_col < vis_w() && cur_row < vis_h())
			put_cell(cur_col, cur_row, screen_mem[cell_addr(cur_col, cur_row)] ^ CURSOR_MARK);
	endfunction

	function automatic void apply_char(logic [7:0] c, bit f, bit l);
		int tgt;
		int base;
		step_ops.delete();
		if (f) begin
			flip_cursor();
			esc_on = 0;
			esc_semi = 0;
			esc_num = 0;
		end
		if (esc_on) begin
			if (c >= CH_0 && c <= CH_9) begin
				if (!esc_semi) begin
					tgt = esc_num * 10 + int'(c - CH_0);
					esc_num = (tgt > 65535) ? 65535 : tgt;
				end
			end else if (c == CH_SEMI) begin
				esc_semi = 1;
			end else begin
				esc_on = 0;
				if (c == CH_K) begin
					if (cur_col < vis_w() && cur_row < vis_h()) begin
						for (int i = cur_col; i < vis_w(); i++)
							screen_mem[cell_addr(i, cur_row)] = CH_SPACE;
						step_ops.push_back('{kind: KIND_CLEAR, col: COL_W'(cur_col),
							row: ROW_W'(cur_row), code: CH_SPACE, last: 1'b0});
					end
				end else if (c == CH_X) begin
					if (esc_num >= vis_w())
						cur_col = (vis_w() > 0) ? vis_w() - 1 : 0;
					else
						cur_col = esc_num;
				end
			end
		end else begin
			case (c)
				CH_CR: cur_col = 0;
				CH_LF: begin
					cur_col = 0;
					if (cur_row + 1 < vis_h()) begin
						cur_row++;
					end else begin
						base = (top % MAX_ROWS) * MAX_COLS;
						for (int i = 0; i < MAX_COLS; i++)
							screen_mem[base + i] = CH_SPACE;
						top = (top + 1) % MAX_ROWS;
						step_ops.push_back('{kind: KIND_SCROLL, col: '0, row: '0, code: '0,
							last: 1'b0});
					end
				end
				CH_TAB: begin
					if ((cur_col & TAB_LAST) != 0) begin
						tgt = (cur_col | TAB_LAST) + 1;
						for (int i = cur_col; i < tgt; i++)
							put_cell(i, cur_row, CH_SPACE);
						cur_col = (tgt > 255) ? 255 : tgt;
					end
				end
				CH_BS: begin
					if (cur_col != 0) begin
						cur_col--;
						put_cell(cur_col, cur_row, CH_SPACE);
					end
				end
				CH_ESC: begin
					esc_on = 1;
					esc_semi = 0;
					esc_num = 0;
				end
				default: begin
					put_cell(cur_col, cur_row, c);
					if (cur_col < 255)
						cur_col++;
				end
			endcase
		end
		if (l)
			flip_cursor();
		if (step_ops.size() != 0)
			step_ops[$].last = 1'b1;
	endfunction

	task automatic send_item(input logic [7:0] c, input bit f, input bit l,
			input bit typed = 0, input result_t typed_res = '0);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			if (gap != 0) begin
				chars_ch.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		chars_ch.valid           <= 1'b1;
		chars_ch.char_code       <= c;
		chars_ch.first_of_string <= f;
		chars_ch.last_of_string  <= l;
		do @(posedge clk); while (!chars_ch.ready);
		sent++;
		apply_char(c, f, l);
		if (typed)
			screen_ops_due.push_back(typed_res);
		else
			foreach (step_ops[i]) screen_ops_due.push_back(step_ops[i]);
	endtask

	// wait out all outstanding requests, including ones that give no result
	task automatic settle();
		chars_ch.valid <= 1'b0;
		burst_left = 0;
		while (screen_ops_due.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [7:0] d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= d;
		do @(posedge clk); while (!cfg_ch.ready);
		if (idx == REG_WIDTH)
			width_reg = d;
		else
			height_reg = d[6:0];
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic logic [7:0] rand_digit();
		return 8'(CH_0 + $urandom_range(0, 9));
	endfunction

	task automatic send_random_sequence();
		logic [7:0] seq[$];
		int n;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick <= 5) begin
			// framed string
			n = $urandom_range(1, 8);
			repeat (n) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: seq.push_back(8'($urandom_range(32, 126)));
					5: begin
						case ($urandom_range(0, 3))
							0: seq.push_back(CH_CR);
							1: seq.push_back(CH_LF);
							2: seq.push_back(CH_TAB);
							default: seq.push_back(CH_BS);
						endcase
					end
					6, 7: begin
						seq.push_back(CH_ESC);
						repeat ($urandom_range(0, 6)) seq.push_back(rand_digit());
						if ($urandom_range(0, 2) == 0) begin
							seq.push_back(CH_SEMI);
							repeat ($urandom_range(0, 3)) seq.push_back(rand_digit());
						end
						case ($urandom_range(0, 4))
							0, 1: seq.push_back(CH_K);
							2, 3: seq.push_back(CH_X);
							default: seq.push_back(8'($urandom));
						endcase
					end
					default: seq.push_back(8'($urandom));
				endcase
			end
			foreach (seq[i]) send_item(seq[i], i == 0, i == seq.size() - 1);
		end else if (pick <= 7) begin
			repeat ($urandom_range(1, 4))
				send_item(8'($urandom), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
		end else begin
			// escape cut short by a new string
			send_item(CH_ESC, 1'b0, 1'b0);
			repeat ($urandom_range(0, 3)) send_item(rand_digit(), 1'b0, 1'b0);
			send_item(8'($urandom), 1'b1, 1'($urandom_range(0, 1)));
		end
	endtask

	function automatic dir_row_t ch_row(logic [7:0] c, bit f, bit l);
		return '{is_cfg: 0, reg_idx: '0, byte_val: c, first: f, last: l, typed: 0, exp: '0};
	endfunction

	function automatic dir_row_t ch_typed(logic [7:0] c, kind_t k, int col, int row,
			logic [7:0] code);
		return '{is_cfg: 0, reg_idx: '0, byte_val: c, first: 0, last: 0, typed: 1,
			exp: '{kind: k, col: COL_W'(col), row: ROW_W'(row), code: code, last: 1'b1}};
	endfunction

	function automatic dir_row_t cfg_row(logic [0:0] idx, logic [7:0] d);
		return '{is_cfg: 1, reg_idx: idx, byte_val: d, first: 0, last: 0, typed: 0, exp: '0};
	endfunction

	// receiver stall pattern
	always @(posedge clk) begin
		rx_cyc <= rx_cyc + 1'b1;
		case (rx_cyc[8:7])
			2'd0: res_ch.ready <= 1'b1;
			2'd1: res_ch.ready <= 1'($urandom_range(0, 1));
			2'd2: res_ch.ready <= (rx_cyc[1:0] == 2'd0);
			default: res_ch.ready <= (rx_cyc[4:0] >= 5'd20);
		endcase
	end

	always @(posedge clk) begin : check_results
		result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (screen_ops_due.size() == 0) begin
				bad_count++;
				if (bad_count <= 10)
					$display("%0t: unexpected result kind %0d col %0d row %0d code %02h last %0b",
						$realtime, res_ch.kind, res_ch.col, res_ch.row, res_ch.code, res_ch.last);
			end else begin
				want = screen_ops_due.pop_front();
				if (res_ch.kind !== want.kind || res_ch.col !== want.col ||
						res_ch.row !== want.row || res_ch.code !== want.code ||
						res_ch.last !== want.last) begin
					bad_count++;
					if (bad_count <= 10)
						$display("%0t: mismatch got %0d/%0d/%0d/%02h/%0b want %0d/%0d/%0d/%02h/%0b",
							$realtime, res_ch.kind, res_ch.col, res_ch.row, res_ch.code,
							res_ch.last, want.kind, want.col, want.row, want.code, want.last);
				end
			end
		end
	end

	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int ph_w[8];
		int ph_h[8];
		int start;
		clk = 1'b0;
		arst_n = 1'b0;
		chars_ch.valid = 1'b0;
		chars_ch.char_code = '0;
		chars_ch.first_of_string = 1'b0;
		chars_ch.last_of_string = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.index = REG_WIDTH;
		cfg_ch.data = '0;
		res_ch.ready = 1'b0;
		foreach (screen_mem[i]) screen_mem[i] = CH_SPACE;
		width_reg = 8'd80;
		height_reg = 7'd25;
		cur_col = 0;
		cur_row = 0;
		top = 0;
		esc_on = 0;
		esc_semi = 0;
		esc_num = 0;

		dir_tab.push_back(ch_typed("A", KIND_CELL, 0, 0, "A"));
		dir_tab.push_back(ch_typed(8'hff, KIND_CELL, 1, 0, 8'hff));
		dir_tab.push_back(ch_typed(8'h00, KIND_CELL, 2, 0, 8'h00));
		dir_tab.push_back(ch_row(CH_TAB, 0, 0));
		dir_tab.push_back(ch_row(CH_TAB, 0, 0));
		dir_tab.push_back(ch_typed(CH_BS, KIND_CELL, 7, 0, CH_SPACE));
		dir_tab.push_back(ch_row(CH_CR, 0, 0));
		dir_tab.push_back(ch_row(CH_LF, 0, 0));
		dir_tab.push_back(ch_row("B", 1, 1));
		// saturating parameter, digits after the separator ignored, clamped column
		dir_tab.push_back(ch_row(CH_ESC, 0, 0));
		dir_tab.push_back(ch_row("7", 0, 0));
		dir_tab.push_back(ch_row("0", 0, 0));
		dir_tab.push_back(ch_row("0", 0, 0));
		dir_tab.push_back(ch_row("0", 0, 0));
		dir_tab.push_back(ch_row("0", 0, 0));
		dir_tab.push_back(ch_row(CH_SEMI, 0, 0));
		dir_tab.push_back(ch_row("3", 0, 0));
		dir_tab.push_back(ch_row(CH_X, 0, 0));
		dir_tab.push_back(ch_row(CH_ESC, 0, 0));
		dir_tab.push_back(ch_typed(CH_K, KIND_CLEAR, 79, 1, CH_SPACE));
		dir_tab.push_back(ch_row(CH_ESC, 0, 0));
		dir_tab.push_back(ch_row("a", 0, 0));
		dir_tab.push_back(ch_typed("5", KIND_CELL, 79, 1, "5"));
		dir_tab.push_back(cfg_row(REG_WIDTH, 8'd8));
		dir_tab.push_back(cfg_row(REG_HEIGHT, 8'd1));
		dir_tab.push_back(ch_typed(CH_LF, KIND_SCROLL, 0, 0, 8'h00));
		dir_tab.push_back(ch_row(CH_ESC, 0, 0));
		dir_tab.push_back(ch_row("Z", 1, 1));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) begin
				settle();
				write_reg(dir_tab[i].reg_idx, dir_tab[i].byte_val);
			end else begin
				send_item(dir_tab[i].byte_val, dir_tab[i].first, dir_tab[i].last,
					dir_tab[i].typed, dir_tab[i].exp);
			end
		end

		ph_w = '{128, 1, 8, 3, 0, 0, 0, 80};
		ph_h = '{64, 1, 4, 2, 0, 0, 0, 25};
		for (int p = 0; p < 8; p++) begin
			settle();
			write_reg(REG_WIDTH, 8'((ph_w[p] != 0) ? ph_w[p] : $urandom_range(1, 128)));
			write_reg(REG_HEIGHT, 8'((ph_h[p] != 0) ? ph_h[p] : $urandom_range(1, 64)));
			if (p == 0) begin
				// run the cursor column into saturation
				send_item(CH_ESC, 1'b0, 1'b0);
				send_item("1", 1'b0, 1'b0);
				send_item("2", 1'b0, 1'b0);
				send_item("7", 1'b0, 1'b0);
				send_item(CH_X, 1'b0, 1'b0);
				repeat (130) send_item(8'($urandom_range(33, 126)), 1'b0, 1'b0);
				send_item(CH_TAB, 1'b0, 1'b0);
				send_item(CH_BS, 1'b0, 1'b0);
				send_item(CH_CR, 1'b0, 1'b1);
			end
			start = sent;
			while (sent - start < 4) send_random_sequence();
		end

		chars_ch.valid <= 1'b0;
		while (screen_ops_due.size() != 0) @(posedge clk);
		repeat (400) @(posedge clk);
		if (bad_count == 0 && screen_ops_due.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
